FILE: hdl/sita_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sita_pkg
// Shared types, sizes and character codes for the integer to ASCII formatter.
// ----------------------------------------------------------------------------
package sita_pkg;

   localparam int VALUE_BITS = 32;
   localparam int HEX_DIGITS = (VALUE_BITS + 3) / 4;
   localparam int DEC_DIGITS = ((VALUE_BITS - 1) * 30103) / 100000 + 1;
   localparam int NUM_DIGITS = (DEC_DIGITS > HEX_DIGITS) ? DEC_DIGITS : HEX_DIGITS;
   localparam int DIGIT_BITS = 4 * NUM_DIGITS;
   localparam int BIN_BITS   = 4 * HEX_DIGITS;
   localparam int IDX_BITS   = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
   localparam int STEPS      = HEX_DIGITS;
   localparam int STEP_BITS  = (STEPS > 1) ? $clog2(STEPS) : 1;
   localparam int FIFO_DEPTH = 2;
   localparam int PTR_BITS   = $clog2(FIFO_DEPTH);

   localparam logic [6:0] CH_ZERO       = 7'h30;
   localparam logic [6:0] CH_ALPHA_BASE = 7'h37;
   localparam logic [6:0] CH_X          = 7'h78;
   localparam logic [6:0] CH_MINUS      = 7'h2D;

   typedef struct packed {
      logic                         cmd;
      logic signed [VALUE_BITS-1:0] value;
   } req_type;

   typedef struct packed {
      logic [6:0] character;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic                  hex;
      logic                  neg;
      logic [VALUE_BITS-1:0] mag;
   } item_type;

   function automatic logic [6:0] digit_char(input logic [3:0] d);
      return (d < 4'd10) ? (CH_ZERO + 7'(d)) : (CH_ALPHA_BASE + 7'(d));
   endfunction

endpackage

FILE: hdl/signed_integer_to_ascii.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_integer_to_ascii
// Formats a signed integer as decimal or 0x-prefixed hexadecimal ASCII text.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; busy rises while
// the two-entry item queue is full. Each value gives its text one character a
// cycle on rsp_payload, marked by rsp_strobe, most significant first, with
// last set on the final character; the receiver cannot stall and must take
// every character as it appears. A decimal value is converted by double dabble,
// four magnitude bits a cycle; a hex value needs no conversion steps.
// Conversion of the next value overlaps output of the current one, so a new
// text starts as soon as the new value is converted and the previous text has
// ended. When idle, a request passes through the item queue, the conversion
// registers and the output registers before its first character appears.
module signed_integer_to_ascii (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  sita_pkg::req_type req_payload,
   output logic              rsp_strobe,
   output sita_pkg::rsp_type rsp_payload
);
   import sita_pkg::*;

   item_type push_item;
   item_type pop_item;
   logic     push;
   logic     pop;
   logic     fifo_full;
   logic     fifo_empty;

   sita_front u_front (
      .start       (start),
      .req_payload (req_payload),
      .fifo_full   (fifo_full),
      .busy        (busy),
      .push        (push),
      .item        (push_item)
   );

   sita_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .wr_data (push_item),
      .pop     (pop),
      .rd_data (pop_item),
      .full    (fifo_full),
      .empty   (fifo_empty)
   );

   sita_back u_back (
      .clock       (clock),
      .reset       (reset),
      .fifo_empty  (fifo_empty),
      .fifo_data   (pop_item),
      .pop         (pop),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

endmodule

FILE: hdl/sita_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sita_front
// Takes a request, splits it into radix, sign and unsigned magnitude, and
// pushes it into the item queue.
// ----------------------------------------------------------------------------
module sita_front (
   input  logic               start,
   input  sita_pkg::req_type  req_payload,
   input  logic               fifo_full,
   output logic               busy,
   output logic               push,
   output sita_pkg::item_type item
);
   import sita_pkg::*;

   logic [VALUE_BITS-1:0] raw;

   assign raw      = req_payload.value;
   assign item.hex = req_payload.cmd;
   assign item.neg = raw[VALUE_BITS-1];
   assign item.mag = raw[VALUE_BITS-1] ? ((~raw) + VALUE_BITS'(1)) : raw;

   assign busy = fifo_full;
   assign push = start & ~fifo_full;

endmodule

FILE: hdl/sita_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sita_fifo
// Short queue of classified items between the front and back parts.
// ----------------------------------------------------------------------------
module sita_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  sita_pkg::item_type wr_data,
   input  logic               pop,
   output sita_pkg::item_type rd_data,
   output logic               full,
   output logic               empty
);
   import sita_pkg::*;

   item_type              entry_ff [FIFO_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PTR_BITS:0]     count_ff, count_in;

   assign full    = (count_ff == (PTR_BITS + 1)'(FIFO_DEPTH));
   assign empty   = (count_ff == '0);
   assign rd_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? (wr_ptr_ff + PTR_BITS'(1)) : wr_ptr_ff;
      rd_ptr_in = pop ? (rd_ptr_ff + PTR_BITS'(1)) : rd_ptr_ff;
      unique case ({push, pop})
         2'b10:   count_in = count_ff + (PTR_BITS + 1)'(1);
         2'b01:   count_in = count_ff - (PTR_BITS + 1)'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("queue written while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset) pop |-> !empty)
      else $error("queue read while empty");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (PTR_BITS + 1)'(FIFO_DEPTH))
      else $error("queue count out of range");

endmodule

FILE: hdl/sita_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sita_back
// Converts decimal magnitudes to digits (double dabble, four bits a cycle) and
// emits the text one character a cycle while the next item converts.
// ----------------------------------------------------------------------------
module sita_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               fifo_empty,
   input  sita_pkg::item_type fifo_data,
   output logic               pop,
   output logic               rsp_strobe,
   output sita_pkg::rsp_type  rsp_payload
);
   import sita_pkg::*;

   typedef enum logic [1:0] {PH_SIGN, PH_ZERO, PH_X, PH_DIGIT} phase_type;

   function automatic logic [DIGIT_BITS-1:0] dabble4(input logic [DIGIT_BITS-1:0] bcd,
                                                      input logic [3:0] bits);
      logic [DIGIT_BITS-1:0] acc;
      acc = bcd;
      for (int s = 3; s >= 0; s--) begin
         for (int k = 0; k < NUM_DIGITS; k++) begin
            if (acc[k*4 +: 4] >= 4'd5) begin
               acc[k*4 +: 4] = acc[k*4 +: 4] + 4'd3;
            end
         end
         acc = {acc[DIGIT_BITS-2:0], bits[s]};
      end
      return acc;
   endfunction

   function automatic logic [IDX_BITS-1:0] top_digit(input logic [DIGIT_BITS-1:0] dig);
      logic [IDX_BITS-1:0] idx;
      idx = '0;
      for (int k = 0; k < NUM_DIGITS; k++) begin
         if (dig[k*4 +: 4] != 4'd0) begin
            idx = IDX_BITS'(k);
         end
      end
      return idx;
   endfunction

   // conversion stage
   logic                  cv_valid_ff, cv_valid_in;
   logic                  cv_done_ff, cv_done_in;
   logic [STEP_BITS-1:0]  cv_step_ff, cv_step_in;
   logic                  cv_hex_ff, cv_neg_ff;
   logic [BIN_BITS-1:0]   cv_bin_ff;
   logic [DIGIT_BITS-1:0] cv_digits_ff;
   logic                  cv_busy;

   // output stage
   logic                  em_valid_ff, em_valid_in;
   phase_type             em_phase_ff, em_phase_in;
   logic [IDX_BITS-1:0]   em_idx_ff, em_idx_in;
   logic                  em_hex_ff;
   logic [DIGIT_BITS-1:0] em_digits_ff;
   logic                  em_last;
   logic                  handoff;

   assign cv_busy = cv_valid_ff & ~cv_done_ff;
   assign em_last = em_valid_ff && (em_phase_ff == PH_DIGIT) && (em_idx_ff == '0);
   assign handoff = cv_valid_ff & cv_done_ff & (~em_valid_ff | em_last);
   assign pop     = ~fifo_empty & (~cv_valid_ff | handoff);

   always_comb begin
      cv_valid_in = cv_valid_ff;
      cv_done_in  = cv_done_ff;
      cv_step_in  = cv_step_ff;
      if (pop) begin
         cv_valid_in = 1'b1;
         cv_done_in  = fifo_data.hex;
         cv_step_in  = '0;
      end else if (handoff) begin
         cv_valid_in = 1'b0;
      end else if (cv_busy) begin
         cv_step_in = cv_step_ff + STEP_BITS'(1);
         if (cv_step_ff == STEP_BITS'(STEPS - 1)) begin
            cv_done_in = 1'b1;
         end
      end
   end

   always_comb begin
      em_valid_in = em_valid_ff;
      em_phase_in = em_phase_ff;
      em_idx_in   = em_idx_ff;
      if (handoff) begin
         em_valid_in = 1'b1;
         em_idx_in   = top_digit(cv_digits_ff);
         if (cv_neg_ff) begin
            em_phase_in = PH_SIGN;
         end else if (cv_hex_ff) begin
            em_phase_in = PH_ZERO;
         end else begin
            em_phase_in = PH_DIGIT;
         end
      end else if (em_valid_ff) begin
         unique case (em_phase_ff)
            PH_SIGN:  em_phase_in = em_hex_ff ? PH_ZERO : PH_DIGIT;
            PH_ZERO:  em_phase_in = PH_X;
            PH_X:     em_phase_in = PH_DIGIT;
            PH_DIGIT: begin
               if (em_idx_ff == '0) begin
                  em_valid_in = 1'b0;
               end else begin
                  em_idx_in = em_idx_ff - IDX_BITS'(1);
               end
            end
            default:  em_phase_in = PH_DIGIT;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cv_valid_ff <= 1'b0;
         cv_done_ff  <= 1'b0;
         cv_step_ff  <= '0;
         em_valid_ff <= 1'b0;
         em_phase_ff <= PH_DIGIT;
         em_idx_ff   <= '0;
      end else begin
         cv_valid_ff <= cv_valid_in;
         cv_done_ff  <= cv_done_in;
         cv_step_ff  <= cv_step_in;
         em_valid_ff <= em_valid_in;
         em_phase_ff <= em_phase_in;
         em_idx_ff   <= em_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cv_hex_ff    <= fifo_data.hex;
         cv_neg_ff    <= fifo_data.neg;
         cv_bin_ff    <= BIN_BITS'(fifo_data.mag);
         cv_digits_ff <= fifo_data.hex ? DIGIT_BITS'(fifo_data.mag) : '0;
      end else if (cv_busy) begin
         cv_bin_ff    <= {cv_bin_ff[BIN_BITS-5:0], 4'd0};
         cv_digits_ff <= dabble4(cv_digits_ff, cv_bin_ff[BIN_BITS-1 -: 4]);
      end
      if (handoff) begin
         em_hex_ff    <= cv_hex_ff;
         em_digits_ff <= cv_digits_ff;
      end
   end

   always_comb begin
      unique case (em_phase_ff)
         PH_SIGN:  rsp_payload.character = CH_MINUS;
         PH_ZERO:  rsp_payload.character = CH_ZERO;
         PH_X:     rsp_payload.character = CH_X;
         PH_DIGIT: rsp_payload.character = digit_char(em_digits_ff[em_idx_ff*4 +: 4]);
         default:  rsp_payload.character = CH_ZERO;
      endcase
   end

   assign rsp_payload.last = em_last;
   assign rsp_strobe       = em_valid_ff;

   a_text_unbroken: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_payload.last) |=> rsp_strobe)
      else $error("gap inside a text");
   a_minus_first: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_payload.character == CH_MINUS)
         |-> (!$past(rsp_strobe) || $past(rsp_payload.last)))
      else $error("minus sign not at start of text");
   a_x_after_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_payload.character == CH_X)
         |-> ($past(rsp_strobe) && $past(rsp_payload.character) == CH_ZERO))
      else $error("hex prefix broken");

endmodule
